// ===== hdl/order_book_level_sweep_top_macros.svh =====
// ----------------------------------------------------------------------------
// order book level sweep assertion macros
// shared concurrent check forms for the sweep block
// ----------------------------------------------------------------------------
`ifndef ORDER_BOOK_LEVEL_SWEEP_TOP_MACROS_SVH
`define ORDER_BOOK_LEVEL_SWEEP_TOP_MACROS_SVH

// same-cycle implication
`define OBLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("obls check failed");

// next-cycle implication
`define OBLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("obls check failed");

`endif

// ===== hdl/obls_pkg.sv =====
// ----------------------------------------------------------------------------
// obls_pkg
// types and constants of the order book level sweep block
// ----------------------------------------------------------------------------
package obls_pkg;

    localparam int BOOK_DEPTH = 8;
    localparam int LVL_W      = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int RAM_AW     = LVL_W + 1;
    localparam int RAM_DEPTH  = 1 << RAM_AW;
    localparam int PX_W       = 32;
    localparam int QTY_W      = 32;
    localparam int ENTRY_W    = PX_W + QTY_W;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_ORDER  = 1'b1;
    localparam logic BOOK_BID    = 1'b0;
    localparam logic BOOK_ASK    = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;
    localparam logic KIND_LIMIT  = 1'b0;
    localparam logic KIND_MARKET = 1'b1;

    typedef logic [LVL_W-1:0]  lvl_t;
    typedef logic [RAM_AW-1:0] ram_addr_t;
    typedef logic [PX_W-1:0]   price_t;
    typedef logic [QTY_W-1:0]  qty_t;

    typedef struct packed {
        logic        func;
        logic [2:0]  level_index;
        logic        book_side;
        logic [31:0] level_price;
        logic [31:0] level_size;
        logic        order_side;
        logic [31:0] order_qty;
        logic [31:0] already_filled;
        logic [31:0] limit_price;
        logic        order_kind;
        logic [31:0] order_tag;
    } in_word_t;

    typedef struct packed {
        logic [31:0] report_tag;
        logic        report_side;
        logic        report_kind;
        logic [31:0] quoted_limit;
        logic [31:0] fill_lots;
        logic [31:0] fill_price;
        logic [31:0] cumulative_qty;
        logic        fully_filled;
        logic        last_of_run;
    } out_word_t;

endpackage

// ===== hdl/obls_ram.sv =====
// ----------------------------------------------------------------------------
// obls_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module obls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/order_book_level_sweep_top.sv =====
// ----------------------------------------------------------------------------
// order_book_level_sweep_top
// two-sided depth-limited book with a level-by-level sweep matcher
//
//   channel  dir  handshake         word
//   s_       in   s_valid/s_ready   obls_pkg::in_word_t  (book write or order)
//   m_       out  m_valid/m_ready   obls_pkg::out_word_t (one fill report)
//
// an order is accepted, then the book levels are examined one by one, then
// the last report is released; the single read port of the book ram paces
// the sweep at one level per cycle while the report register is free.
// reset empties the book at once through per-entry valid bits.
// a stalled result side holds the sweep until the report register frees up.
// ----------------------------------------------------------------------------
`include "order_book_level_sweep_top_macros.svh"

module order_book_level_sweep_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  obls_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output obls_pkg::out_word_t m_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    state_t              state_reg, state_next;
    obls_pkg::lvl_t      lvl_reg, lvl_next;
    obls_pkg::qty_t      rem_reg, rem_next;
    obls_pkg::qty_t      cum_reg, cum_next;
    logic                side_reg, side_next;
    logic                kind_reg, kind_next;
    obls_pkg::price_t    limit_reg, limit_next;
    logic [31:0]         tag_reg, tag_next;
    logic                pend_valid_reg, pend_valid_next;
    obls_pkg::out_word_t pend_word_reg, pend_word_next;
    logic                m_valid_reg, m_valid_next;
    obls_pkg::out_word_t m_word_reg, m_word_next;
    logic                valid_reg [obls_pkg::RAM_DEPTH];
    logic                vld_q_reg;

    logic                        ram_we;
    obls_pkg::ram_addr_t         ram_waddr;
    logic [obls_pkg::ENTRY_W-1:0] ram_wdata;
    logic                        ram_re;
    obls_pkg::ram_addr_t         ram_raddr;
    logic [obls_pkg::ENTRY_W-1:0] ram_rdata;

    obls_pkg::price_t lvl_px;
    obls_pkg::qty_t   lvl_sz;
    logic             lvl_ok;
    obls_pkg::qty_t   take;
    obls_pkg::qty_t   rem_new;
    obls_pkg::qty_t   cum_new;
    logic             last_lvl;
    logic             out_free;
    logic             book_sel;
    logic             in_range;
    obls_pkg::qty_t   rem_start;

    obls_ram #(
        .WIDTH (obls_pkg::ENTRY_W),
        .DEPTH (obls_pkg::RAM_DEPTH)
    ) u_book (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign lvl_px   = ram_rdata[obls_pkg::ENTRY_W-1:obls_pkg::QTY_W];
    assign lvl_sz   = ram_rdata[obls_pkg::QTY_W-1:0];
    assign take     = (rem_reg < lvl_sz) ? rem_reg : lvl_sz;
    assign rem_new  = rem_reg - take;
    assign cum_new  = cum_reg + take;
    assign last_lvl = (lvl_reg == obls_pkg::lvl_t'(obls_pkg::BOOK_DEPTH - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign in_range = (32'(s_word.level_index) < 32'(obls_pkg::BOOK_DEPTH));
    assign book_sel = (s_word.order_side == obls_pkg::SIDE_BUY) ? obls_pkg::BOOK_ASK
                                                                 : obls_pkg::BOOK_BID;
    assign rem_start = (s_word.order_qty > s_word.already_filled)
                     ? (s_word.order_qty - s_word.already_filled) : '0;

    always_comb begin
        if (!vld_q_reg || lvl_px == '0 || lvl_sz == '0) begin
            lvl_ok = 1'b0;
        end else if (kind_reg == obls_pkg::KIND_MARKET) begin
            lvl_ok = 1'b1;
        end else if (side_reg == obls_pkg::SIDE_BUY) begin
            lvl_ok = (lvl_px <= limit_reg);
        end else begin
            lvl_ok = (lvl_px >= limit_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        lvl_next        = lvl_reg;
        rem_next        = rem_reg;
        cum_next        = cum_reg;
        side_next       = side_reg;
        kind_next       = kind_reg;
        limit_next      = limit_reg;
        tag_next        = tag_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_word_next     = m_word_reg;
        ram_we          = 1'b0;
        ram_waddr       = {s_word.book_side, obls_pkg::lvl_t'(s_word.level_index)};
        ram_wdata       = {s_word.level_price, s_word.level_size};
        ram_re          = 1'b0;
        ram_raddr       = {book_sel, obls_pkg::lvl_t'(0)};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_word.func == obls_pkg::FUNC_WRITE) begin
                        ram_we = in_range;
                    end else begin
                        side_next  = s_word.order_side;
                        kind_next  = s_word.order_kind;
                        limit_next = s_word.limit_price;
                        tag_next   = s_word.order_tag;
                        rem_next   = rem_start;
                        cum_next   = s_word.already_filled;
                        lvl_next   = '0;
                        if (rem_start != '0) begin
                            ram_re     = 1'b1;
                            state_next = ST_SWEEP;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                ram_raddr = {~side_reg, lvl_reg + obls_pkg::lvl_t'(1)};
                if (!lvl_ok) begin
                    state_next = pend_valid_reg ? ST_DRAIN : ST_IDLE;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_word_next  = pend_word_reg;
                    end
                    pend_valid_next               = 1'b1;
                    pend_word_next.report_tag     = tag_reg;
                    pend_word_next.report_side    = side_reg;
                    pend_word_next.report_kind    = kind_reg;
                    pend_word_next.quoted_limit   =
                        (kind_reg == obls_pkg::KIND_MARKET) ? '0 : limit_reg;
                    pend_word_next.fill_lots      = take;
                    pend_word_next.fill_price     = lvl_px;
                    pend_word_next.cumulative_qty = cum_new;
                    pend_word_next.fully_filled   = (rem_new == '0);
                    pend_word_next.last_of_run    = 1'b0;
                    rem_next = rem_new;
                    cum_next = cum_new;
                    lvl_next = lvl_reg + obls_pkg::lvl_t'(1);
                    if (rem_new == '0 || last_lvl) begin
                        state_next = ST_DRAIN;
                    end else begin
                        ram_re = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_word_next              = pend_word_reg;
                    m_word_next.last_of_run  = 1'b1;
                    pend_valid_next          = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            vld_q_reg      <= 1'b0;
            for (int i = 0; i < obls_pkg::RAM_DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (ram_re) begin
                vld_q_reg <= valid_reg[ram_raddr];
            end
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
        lvl_reg       <= lvl_next;
        rem_reg       <= rem_next;
        cum_reg       <= cum_next;
        side_reg      <= side_next;
        kind_reg      <= kind_next;
        limit_reg     <= limit_next;
        tag_reg       <= tag_next;
        pend_word_reg <= pend_word_next;
        m_word_reg    <= m_word_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    `OBLS_ASSERT_IMPLY(a_full_is_last, aclk, aresetn, m_valid && m_word.fully_filled, m_word.last_of_run)
    `OBLS_ASSERT_IMPLY(a_cum_covers_fill, aclk, aresetn, m_valid, m_word.cumulative_qty >= m_word.fill_lots)
    `OBLS_ASSERT_IMPLY(a_idle_no_pending, aclk, aresetn, state_reg == ST_IDLE, !pend_valid_reg)
    `OBLS_ASSERT_NEXT(a_drain_leaves, aclk, aresetn, state_reg == ST_DRAIN && out_free, state_reg == ST_IDLE && m_valid)

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the order book level sweep block. book writes and
// orders go in through a queued valid/ready driver. a behavioral book sweep
// predicts every fill report, and the monitor checks each report field by
// field in arrival order. a directed opening is followed by randomized book
// rebuilds and orders, with random idling on both channels, one long result
// stall and pauses that let the block drain.
// ----------------------------------------------------------------------------
module tb_top;
    import obls_pkg::*;

    localparam int N_RANDOM       = 93;
    localparam int PHASE_LEN      = 50;
    localparam int HOLD_AT        = 40;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTED   = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    // book copy kept by the predictor
    price_t bid_px [BOOK_DEPTH];
    qty_t   bid_sz [BOOK_DEPTH];
    price_t ask_px [BOOK_DEPTH];
    qty_t   ask_sz [BOOK_DEPTH];

    in_word_t  word_q[$];
    bit        drain_q[$];
    out_word_t expected_fills[$];

    int n_accepted   = 0;
    int n_writes     = 0;
    int n_orders     = 0;
    int n_market     = 0;
    int n_empty      = 0;
    int n_deep       = 0;
    int n_fills      = 0;
    int n_errors     = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    int idle_cycles  = 0;

    order_book_level_sweep_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // book update or sweep of one accepted word
    function automatic void apply_book_word(input in_word_t w);
        price_t    px;
        qty_t      sz;
        qty_t      remaining;
        qty_t      cum;
        qty_t      take;
        logic      ok;
        bit        stop;
        bit        have;
        int        n;
        out_word_t r;
        out_word_t held;
        if (w.func == FUNC_WRITE) begin
            n_writes++;
            if (int'(w.level_index) < BOOK_DEPTH) begin
                if (w.book_side == BOOK_BID) begin
                    bid_px[w.level_index] = w.level_price;
                    bid_sz[w.level_index] = w.level_size;
                end else begin
                    ask_px[w.level_index] = w.level_price;
                    ask_sz[w.level_index] = w.level_size;
                end
            end
            return;
        end
        n_orders++;
        if (w.order_kind == KIND_MARKET) n_market++;
        remaining = (w.order_qty > w.already_filled) ? w.order_qty - w.already_filled : '0;
        cum  = w.already_filled;
        stop = 1'b0;
        have = 1'b0;
        n    = 0;
        held = '0;
        for (int lvl = 0; lvl < BOOK_DEPTH; lvl++) begin
            if (!stop && remaining != '0) begin
                px = (w.order_side == SIDE_BUY) ? ask_px[lvl] : bid_px[lvl];
                sz = (w.order_side == SIDE_BUY) ? ask_sz[lvl] : bid_sz[lvl];
                if (px == '0 || sz == '0) begin
                    stop = 1'b1;
                end else begin
                    if (w.order_kind == KIND_MARKET) ok = 1'b1;
                    else if (w.order_side == SIDE_BUY) ok = (px <= w.limit_price);
                    else ok = (px >= w.limit_price);
                    if (!ok) begin
                        stop = 1'b1;
                    end else begin
                        take      = (remaining < sz) ? remaining : sz;
                        remaining = remaining - take;
                        cum       = cum + take;
                        r.report_tag     = w.order_tag;
                        r.report_side    = w.order_side;
                        r.report_kind    = w.order_kind;
                        r.quoted_limit   = (w.order_kind == KIND_LIMIT) ? w.limit_price : '0;
                        r.fill_lots      = take;
                        r.fill_price     = px;
                        r.cumulative_qty = cum;
                        r.fully_filled   = (remaining == '0);
                        r.last_of_run    = 1'b0;
                        if (have) expected_fills.insert(expected_fills.size(), held);
                        held = r;
                        have = 1'b1;
                        n++;
                    end
                end
            end
        end
        if (have) begin
            held.last_of_run = 1'b1;
            expected_fills.insert(expected_fills.size(), held);
        end else begin
            n_empty++;
        end
        if (n == BOOK_DEPTH) n_deep++;
    endfunction

    task automatic check_report(input out_word_t got, input out_word_t want);
        string bad;
        bad = "";
        if (got.report_tag     !== want.report_tag)     bad = {bad, " report_tag"};
        if (got.report_side    !== want.report_side)    bad = {bad, " report_side"};
        if (got.report_kind    !== want.report_kind)    bad = {bad, " report_kind"};
        if (got.quoted_limit   !== want.quoted_limit)   bad = {bad, " quoted_limit"};
        if (got.fill_lots      !== want.fill_lots)      bad = {bad, " fill_lots"};
        if (got.fill_price     !== want.fill_price)     bad = {bad, " fill_price"};
        if (got.cumulative_qty !== want.cumulative_qty) bad = {bad, " cumulative_qty"};
        if (got.fully_filled   !== want.fully_filled)   bad = {bad, " fully_filled"};
        if (got.last_of_run    !== want.last_of_run)    bad = {bad, " last_of_run"};
        if (bad != "") begin
            n_errors++;
            if (n_errors <= MAX_REPORTED) begin
                $display("%0t fill mismatch on%s", $realtime, bad);
                $display("  expected tag=%h side=%b kind=%b lim=%h qty=%h px=%h cum=%h full=%b last=%b",
                         want.report_tag, want.report_side, want.report_kind, want.quoted_limit,
                         want.fill_lots, want.fill_price, want.cumulative_qty,
                         want.fully_filled, want.last_of_run);
                $display("  actual   tag=%h side=%b kind=%b lim=%h qty=%h px=%h cum=%h full=%b last=%b",
                         got.report_tag, got.report_side, got.report_kind, got.quoted_limit,
                         got.fill_lots, got.fill_price, got.cumulative_qty,
                         got.fully_filled, got.last_of_run);
            end
        end
    endtask

    // sender
    always @(posedge aclk) begin : drive_words
        logic     nxt_valid;
        in_word_t nxt_word;
        int       idle_pct;
        nxt_valid = s_valid;
        nxt_word  = s_word;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_book_word(s_word);
                n_accepted <= n_accepted + 1;
                nxt_valid = 1'b0;
            end
            idle_pct = (n_accepted < PHASE_LEN) ? 38 : (n_accepted < 2 * PHASE_LEN) ? 64 : 0;
            if (!nxt_valid && word_q.size() != 0
                    && !(drain_q[0] && expected_fills.size() != 0)
                    && $urandom_range(0, 99) >= idle_pct) begin
                nxt_word  = word_q[0];
                word_q.delete(0);
                drain_q.delete(0);
                nxt_valid = 1'b1;
            end
        end
        s_valid <= nxt_valid;
        s_word  <= nxt_word;
    end

    // receiver ready, with one long stall while the sender keeps going
    always @(posedge aclk) begin : drive_ready
        int idle_pct;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!holdoff_done && n_accepted >= HOLD_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLD_CYCLES;
            end
            idle_pct = (n_accepted < PHASE_LEN) ? 64 : (n_accepted < 2 * PHASE_LEN) ? 38 : 0;
            if (holdoff_left > 0) begin
                holdoff_left = holdoff_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : watch_reports
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            n_fills++;
            if (expected_fills.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTED)
                    $display("%0t unexpected fill report tag=%h px=%h qty=%h", $realtime,
                             m_word.report_tag, m_word.fill_price, m_word.fill_lots);
            end else begin
                want = expected_fills[0];
                expected_fills.delete(0);
                check_report(m_word, want);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no traffic for %0d cycles, %0d fills still expected",
                     idle_cycles, expected_fills.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic in_word_t random_word();
        in_word_t w;
        w.func           = 1'($urandom_range(0, 1));
        w.level_index    = 3'($urandom_range(0, 7));
        w.book_side      = 1'($urandom_range(0, 1));
        w.level_price    = $urandom;
        w.level_size     = $urandom;
        w.order_side     = 1'($urandom_range(0, 1));
        w.order_qty      = $urandom;
        w.already_filled = $urandom;
        w.limit_price    = $urandom;
        w.order_kind     = 1'($urandom_range(0, 1));
        w.order_tag      = $urandom;
        return w;
    endfunction

    function automatic in_word_t level_write(input logic side, input int unsigned idx,
                                             input price_t px, input qty_t sz);
        in_word_t w;
        w = random_word();
        w.func        = FUNC_WRITE;
        w.book_side   = side;
        w.level_index = idx[2:0];
        w.level_price = px;
        w.level_size  = sz;
        return w;
    endfunction

    function automatic in_word_t order_word(input logic side, input logic kind, input qty_t qty,
                                            input qty_t filled, input price_t lim);
        in_word_t w;
        w = random_word();
        w.func           = FUNC_ORDER;
        w.order_side     = side;
        w.order_kind     = kind;
        w.order_qty      = qty;
        w.already_filled = filled;
        w.limit_price    = lim;
        return w;
    endfunction

    task automatic queue_word(input in_word_t w, input bit drain = 1'b0);
        word_q.insert(word_q.size(), w);
        drain_q.insert(drain_q.size(), drain);
    endtask

    // sorted book side with random sizes and the odd empty level
    task automatic rebuild_side(input logic side, input int unsigned base);
        int unsigned px;
        qty_t        sz;
        px = base;
        for (int lvl = 0; lvl < BOOK_DEPTH; lvl++) begin
            if (lvl > 0) begin
                if (side == BOOK_ASK) px = px + $urandom_range(0, 4);
                else px = px - $urandom_range(0, 4);
            end
            sz = ($urandom_range(0, 9) == 0) ? qty_t'($urandom) : qty_t'($urandom_range(1, 60));
            case ($urandom_range(0, 15))
                0: queue_word(level_write(side, lvl, '0, sz));
                1: queue_word(level_write(side, lvl, px, '0));
                default: queue_word(level_write(side, lvl, px, sz));
            endcase
        end
    endtask

    initial begin : stimulus
        int unsigned ask_base;
        int unsigned bid_base;
        int          n_directed;
        int          drain_at;
        logic        side;
        logic        kind;
        qty_t        qty;
        qty_t        filled;
        price_t      lim;
        price_t      ask_seed [BOOK_DEPTH];
        qty_t        ask_size [BOOK_DEPTH];
        price_t      bid_seed [BOOK_DEPTH];
        qty_t        bid_size [BOOK_DEPTH];

        for (int i = 0; i < BOOK_DEPTH; i++) begin
            bid_px[i] = '0;
            bid_sz[i] = '0;
            ask_px[i] = '0;
            ask_sz[i] = '0;
        end

        ask_seed = '{100, 101, 102, 102, 105, 110, 120, 32'hFFFF_FFFF};
        ask_size = '{3, 1, 2, 4, 6, 10, 1000, 32'hFFFF_FFFF};
        bid_seed = '{99, 98, 97, 90, 80, 50, 2, 1};
        bid_size = '{5, 5, 5, 7, 9, 11, 13, 32'hFFFF_FFFF};

        // empty book
        queue_word(order_word(SIDE_BUY, KIND_MARKET, 10, 0, 0));
        for (int i = 0; i < BOOK_DEPTH; i++) queue_word(level_write(BOOK_ASK, i, ask_seed[i], ask_size[i]));
        for (int i = 0; i < BOOK_DEPTH; i++) queue_word(level_write(BOOK_BID, i, bid_seed[i], bid_size[i]));
        queue_word(order_word(SIDE_BUY,  KIND_MARKET, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
        queue_word(order_word(SIDE_BUY,  KIND_LIMIT, 7, 0, 102));
        queue_word(order_word(SIDE_SELL, KIND_LIMIT, 50, 10, 97));
        queue_word(order_word(SIDE_SELL, KIND_LIMIT, 30, 0, 0));
        queue_word(order_word(SIDE_SELL, KIND_MARKET, 32'hFFFF_FFFF, 0, 0));
        queue_word(order_word(SIDE_BUY,  KIND_LIMIT, 20, 0, 0), 1'b1);
        queue_word(order_word(SIDE_BUY,  KIND_LIMIT, 20, 20, 32'hFFFF_FFFF));
        queue_word(order_word(SIDE_SELL, KIND_MARKET, 5, 32'hFFFF_FFFF, 0));
        queue_word(level_write(BOOK_ASK, 2, 0, 50));
        queue_word(order_word(SIDE_BUY,  KIND_MARKET, 1000, 0, 0));
        n_directed = word_q.size();

        ask_base = 100;
        bid_base = 99;
        drain_at = n_directed + 70;
        while (word_q.size() < n_directed + N_RANDOM) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    ask_base = $urandom_range(1000, 5000);
                    bid_base = ask_base - $urandom_range(1, 10);
                    rebuild_side(BOOK_ASK, ask_base);
                    rebuild_side(BOOK_BID, bid_base);
                end
                2: begin
                    queue_word(level_write(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                               ($urandom_range(0, 3) == 0) ? price_t'(0) : price_t'($urandom),
                               ($urandom_range(0, 3) == 0) ? qty_t'(0) : qty_t'($urandom)));
                end
                default: begin
                    side = 1'($urandom_range(0, 1));
                    kind = ($urandom_range(0, 3) == 0) ? KIND_MARKET : KIND_LIMIT;
                    case ($urandom_range(0, 19))
                        0, 1, 2:    qty = $urandom;
                        3, 4, 5:    qty = $urandom_range(1, 5);
                        default:    qty = $urandom_range(1, 300);
                    endcase
                    case ($urandom_range(0, 19))
                        0, 1, 2:       filled = $urandom;
                        3, 4, 5, 6, 7: filled = $urandom_range(0, int'(qty[15:0]));
                        default:       filled = '0;
                    endcase
                    case ($urandom_range(0, 19))
                        0:       lim = '0;
                        1:       lim = 32'hFFFF_FFFF;
                        2:       lim = $urandom;
                        default: lim = (side == SIDE_BUY) ? ask_base + $urandom_range(0, 30) - 3
                                                          : bid_base - $urandom_range(0, 30) + 3;
                    endcase
                    queue_word(order_word(side, kind, qty, filled, lim),
                               word_q.size() >= drain_at && word_q.size() < drain_at + 1);
                end
            endcase
        end

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        while (word_q.size() != 0 || s_valid) @(posedge aclk);
        while (expected_fills.size() != 0) @(posedge aclk);
        repeat (BOOK_DEPTH + 4) @(posedge aclk);

        if (expected_fills.size() != 0) n_errors++;
        $display("covered %0d book writes and %0d orders (%0d market, %0d with no fill)",
                 n_writes, n_orders, n_market, n_empty);
        $display("checked %0d fill reports, %0d sweeps took every level, %0d mismatches",
                 n_fills, n_deep, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
